### hdl/dscs_pkg.sv
// ----------------------------------------------------------------------------
// dscs_pkg
// Shared widths and control types for the descending score sorter.
// ----------------------------------------------------------------------------
package dscs_pkg;

  localparam int TAG_W   = 16;
  localparam int SCORE_W = 16;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the incoming element at its rank
    logic shift;   // move every entry one place toward the head
  } dscs_ctl_t;

endpackage

### hdl/dscs_if.sv
// ----------------------------------------------------------------------------
// dscs_if
// Valid/ready channels for elements in and ranked results out.
// ----------------------------------------------------------------------------
interface dscs_in_if;
  logic                        valid;
  logic                        ready;
  logic [dscs_pkg::TAG_W-1:0]   element_tag;
  logic [dscs_pkg::SCORE_W-1:0] score;
  logic                        last_element;

  modport source (output valid, element_tag, score, last_element, input ready);
  modport sink   (input valid, element_tag, score, last_element, output ready);
endinterface

interface dscs_out_if;
  logic                        valid;
  logic                        ready;
  logic [dscs_pkg::TAG_W-1:0]   sorted_tag;
  logic [dscs_pkg::SCORE_W-1:0] sorted_score;
  logic                        last_result;
  logic                        overflow;

  modport source (output valid, sorted_tag, sorted_score, last_result, overflow,
                  input ready);
  modport sink   (input valid, sorted_tag, sorted_score, last_result, overflow,
                  output ready);
endinterface

### hdl/descending_score_counting_sort_top.sv
// ----------------------------------------------------------------------------
// descending_score_counting_sort_top
// Loads a set of tagged scores and streams them back highest score first.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while loading; each goes straight to its
// rank in a chain of CAPACITY cells, so the set is already in order when the
// element marked last arrives. The chain then shifts toward its head and one
// result leaves per cycle while the sink keeps ready high: the first result is
// offered once the state has turned to emission and the head entry has been
// registered at the output, and the next set can start once the remaining
// count reaches zero and the state returns to loading. No input is taken
// while results are streaming. Equal scores come out newest first; elements
// beyond CAPACITY are dropped and every result of that set carries overflow.
module descending_score_counting_sort_top #(
  parameter int CAPACITY   = 64,
  parameter int SCORE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  dscs_in_if.sink          in_ch,
  dscs_out_if.source       out_ch
);
  import dscs_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {S_LOAD, S_EMIT} state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [CNT_W-1:0]      remain_r, remain_nxt;
  logic                  drop_r, drop_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [TAG_W-1:0]      out_tag_r;
  logic [SCORE_W-1:0]    out_score_r;
  logic                  out_last_r;
  logic                  out_ovf_r;

  logic                  accept, full, take_out, shift;
  dscs_ctl_t             ctl;
  logic                  head_valid;
  logic [TAG_W-1:0]      head_tag;
  logic [SCORE_BITS-1:0] head_score;

  assign in_ch.ready = (state_r == S_LOAD);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (fill_r == CNT_W'(CAPACITY));
  assign take_out    = !out_valid_r || out_ch.ready;
  assign shift       = (state_r == S_EMIT) && (remain_r != '0) && take_out;

  assign ctl.insert = accept && !full;
  assign ctl.shift  = shift;

  dscs_chain #(
    .CAPACITY   (CAPACITY),
    .SCORE_BITS (SCORE_BITS)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .new_tag    (in_ch.element_tag),
    .new_score  (in_ch.score[SCORE_BITS-1:0]),
    .head_valid (head_valid),
    .head_tag   (head_tag),
    .head_score (head_score)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    remain_nxt    = remain_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            fill_nxt = fill_r + CNT_W'(1);
          end
          if (in_ch.last_element) begin
            remain_nxt = full ? fill_r : fill_r + CNT_W'(1);
            state_nxt  = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (remain_r == '0) begin
          state_nxt = S_LOAD;
          fill_nxt  = '0;
          drop_nxt  = 1'b0;
        end else if (shift) begin
          remain_nxt    = remain_r - CNT_W'(1);
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      remain_r    <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      remain_r    <= remain_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (shift) begin
      out_tag_r   <= head_tag;
      out_score_r <= SCORE_W'(head_score);
      out_last_r  <= (remain_r == CNT_W'(1));
      out_ovf_r   <= drop_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_tag   = out_tag_r;
  assign out_ch.sorted_score = out_score_r;
  assign out_ch.last_result  = out_last_r;
  assign out_ch.overflow     = out_ovf_r;

  // the count never passes the number of cells
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // every shift-out finds an occupied head cell
  a_head_on_shift: assert property (@(posedge clk) disable iff (!rst_n)
    shift |-> head_valid)
    else $error("shift-out from empty chain");

  // an empty set leaves the chain empty
  a_empty_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && fill_r == '0) |-> !head_valid)
    else $error("chain holds entries with zero fill count");

  // no request is taken while results stream
  a_no_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    shift |-> !ctl.insert)
    else $error("insert during emission");

endmodule

### hdl/dscs_cell.sv
// ----------------------------------------------------------------------------
// dscs_cell
// One slot of the sorting chain: holds an entry, compares it with the
// incoming element and takes the new element, its upper neighbor's entry
// or its lower neighbor's entry.
// ----------------------------------------------------------------------------
module dscs_cell #(
  parameter int SCORE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dscs_pkg::dscs_ctl_t        ctl,
  input  logic [dscs_pkg::TAG_W-1:0] new_tag,
  input  logic [SCORE_BITS-1:0]      new_score,
  input  logic                       prev_valid,
  input  logic [dscs_pkg::TAG_W-1:0] prev_tag,
  input  logic [SCORE_BITS-1:0]      prev_score,
  input  logic                       prev_disp,
  input  logic                       next_valid,
  input  logic [dscs_pkg::TAG_W-1:0] next_tag,
  input  logic [SCORE_BITS-1:0]      next_score,
  output logic                       valid,
  output logic [dscs_pkg::TAG_W-1:0] tag,
  output logic [SCORE_BITS-1:0]      score,
  output logic                       disp
);
  import dscs_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [TAG_W-1:0]      tag_r, tag_nxt;
  logic [SCORE_BITS-1:0] score_r, score_nxt;

  // newer element wins ties, so it goes in front of an equal score
  assign disp = !valid_r || (new_score >= score_r);

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    score_nxt = score_r;
    if (ctl.insert && disp) begin
      if (prev_disp) begin
        valid_nxt = prev_valid;
        tag_nxt   = prev_tag;
        score_nxt = prev_score;
      end else begin
        valid_nxt = 1'b1;
        tag_nxt   = new_tag;
        score_nxt = new_score;
      end
    end else if (ctl.shift) begin
      valid_nxt = next_valid;
      tag_nxt   = next_tag;
      score_nxt = next_score;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    tag_r   <= tag_nxt;
    score_r <= score_nxt;
  end

  assign valid = valid_r;
  assign tag   = tag_r;
  assign score = score_r;

endmodule

### hdl/dscs_chain.sv
// ----------------------------------------------------------------------------
// dscs_chain
// Row of sorting cells kept in descending score order, head at cell zero.
// ----------------------------------------------------------------------------
module dscs_chain #(
  parameter int CAPACITY   = 64,
  parameter int SCORE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dscs_pkg::dscs_ctl_t        ctl,
  input  logic [dscs_pkg::TAG_W-1:0] new_tag,
  input  logic [SCORE_BITS-1:0]      new_score,
  output logic                       head_valid,
  output logic [dscs_pkg::TAG_W-1:0] head_tag,
  output logic [SCORE_BITS-1:0]      head_score
);
  import dscs_pkg::*;

  logic                  valid_w [CAPACITY];
  logic [TAG_W-1:0]      tag_w   [CAPACITY];
  logic [SCORE_BITS-1:0] score_w [CAPACITY];
  logic                  disp_w  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  p_valid, p_disp, n_valid;
    logic [TAG_W-1:0]      p_tag, n_tag;
    logic [SCORE_BITS-1:0] p_score, n_score;

    if (i == 0) begin : g_head
      assign p_valid = 1'b0;
      assign p_tag   = '0;
      assign p_score = '0;
      assign p_disp  = 1'b0;
    end else begin : g_body
      assign p_valid = valid_w[i-1];
      assign p_tag   = tag_w[i-1];
      assign p_score = score_w[i-1];
      assign p_disp  = disp_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_tag   = '0;
      assign n_score = '0;
    end else begin : g_mid
      assign n_valid = valid_w[i+1];
      assign n_tag   = tag_w[i+1];
      assign n_score = score_w[i+1];
    end

    dscs_cell #(.SCORE_BITS(SCORE_BITS)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_tag    (new_tag),
      .new_score  (new_score),
      .prev_valid (p_valid),
      .prev_tag   (p_tag),
      .prev_score (p_score),
      .prev_disp  (p_disp),
      .next_valid (n_valid),
      .next_tag   (n_tag),
      .next_score (n_score),
      .valid      (valid_w[i]),
      .tag        (tag_w[i]),
      .score      (score_w[i]),
      .disp       (disp_w[i])
    );
  end

  assign head_valid = valid_w[0];
  assign head_tag   = tag_w[0];
  assign head_score = score_w[0];

endmodule

### tb/descending_score_counting_sort_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// descending_score_counting_sort_top_tb
// Sends sets of tagged scores into the sorter and checks every ranked result
// against an in-bench ranking of the same set: highest score first, newest
// first among equal scores, overflow marked on sets that lost elements.
// ----------------------------------------------------------------------------
module descending_score_counting_sort_top_tb;
  import dscs_pkg::*;

  localparam int CAPACITY = 64;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
    logic               last;
    logic               hold;   // wait until all results of earlier sets are back
  } element_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
    logic               last;
    logic               overflow;
  } ranked_t;

  logic clk = 1'b0;
  logic rst_n;

  dscs_in_if  in_ch ();
  dscs_out_if out_ch ();

  descending_score_counting_sort_top #(
    .CAPACITY   (CAPACITY),
    .SCORE_BITS (SCORE_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  element_t element_q[$];
  ranked_t  ranked_q[$];

  // bench copy of the sorter store
  logic [TAG_W-1:0]   tag_mem[CAPACITY];
  logic [SCORE_W-1:0] score_mem[CAPACITY];
  int                 fill_cnt = 0;
  bit                 dropped = 1'b0;

  int       mismatches = 0;
  element_t cur = '0;
  bit       offering = 1'b0;
  int       tx_wait = 0;
  int       rx_wait = 0;
  bit       tx_burst = 1'b0;
  bit       rx_burst = 1'b0;
  int       hold_left = 0;
  bit       hold_used = 1'b0;

  function automatic int pick_gap(input bit burst);
    return burst ? 0 : int'($urandom_range(0, 6));
  endfunction

  // store one element; on the last one rank the whole set
  task automatic load_element(input element_t e);
    int      order[CAPACITY];
    int      n;
    int      pos;
    ranked_t r;
    if (fill_cnt < CAPACITY) begin
      tag_mem[fill_cnt]   = e.tag;
      score_mem[fill_cnt] = e.score;
      fill_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (e.last) begin
      n = fill_cnt;
      for (int i = 0; i < n; i++) begin
        pos = 0;
        for (int j = 0; j < n; j++)
          if (j != i && (score_mem[j] > score_mem[i] ||
                         (score_mem[j] == score_mem[i] && j > i)))
            pos++;
        order[pos] = i;
      end
      for (int p = 0; p < n; p++) begin
        r.tag      = tag_mem[order[p]];
        r.score    = score_mem[order[p]];
        r.last     = (p == n - 1);
        r.overflow = dropped;
        ranked_q.push_back(r);
      end
      fill_cnt = 0;
      dropped  = 1'b0;
    end
  endtask

  task automatic push_element(input logic [15:0] tag, input logic [15:0] score,
                              input bit last, input bit hold);
    element_t e;
    e.tag   = tag;
    e.score = score;
    e.last  = last;
    e.hold  = hold;
    element_q.push_back(e);
  endtask

  // style 0: any score, 1: few distinct scores with extremes, 2: all equal
  task automatic queue_set(input int n, input int style, input bit hold_first);
    logic [15:0] base;
    logic [15:0] score;
    base = 16'($urandom_range(0, 65535));
    for (int k = 0; k < n; k++) begin
      case (style)
        0: score = 16'($urandom_range(0, 65535));
        1: begin
          case ($urandom_range(0, 3))
            0: score = 16'h0000;
            1: score = 16'hFFFF;
            2: score = base;
            default: score = base ^ 16'h0001;
          endcase
        end
        default: score = base;
      endcase
      push_element(16'($urandom_range(0, 65535)), score, k == n - 1,
                   hold_first && k == 0);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.element_tag  <= '0;
      in_ch.score        <= '0;
      in_ch.last_element <= 1'b0;
      offering = 1'b0;
      tx_wait  = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        load_element(cur);
        offering = 1'b0;
        tx_wait  = pick_gap(tx_burst);
        if ($urandom_range(0, 15) == 0)
          tx_burst = !tx_burst;
      end
      if (!offering) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (element_q.size() > 0 &&
                     !(element_q[0].hold && ranked_q.size() > 0)) begin
          cur      = element_q.pop_front();
          offering = 1'b1;
        end
      end
      in_ch.valid        <= offering;
      in_ch.element_tag  <= cur.tag;
      in_ch.score        <= cur.score;
      in_ch.last_element <= cur.last;
    end
  end

  // long receiver hold-off on the first overflowed set, so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && out_ch.valid && out_ch.overflow) begin
      hold_left <= 300;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    ranked_t got;
    ranked_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.sorted_tag, out_ch.sorted_score, out_ch.last_result,
               out_ch.overflow};
        if (ranked_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with none pending: tag %h score %h last %b ovf %b",
                     $time, got.tag, got.score, got.last, got.overflow);
          mismatches++;
        end else begin
          want = ranked_q.pop_front();
          if (got != want) begin
            if (mismatches < 10)
              $display("%0t: exp %h/%h last %b ovf %b, got %h/%h last %b ovf %b",
                       $time, want.tag, want.score, want.last, want.overflow,
                       got.tag, got.score, got.last, got.overflow);
            mismatches++;
          end
        end
        rx_wait = pick_gap(rx_burst);
        if ($urandom_range(0, 15) == 0)
          rx_burst = !rx_burst;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ch.ready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int total;
    int n;
    rst_n = 1'b0;

    // single element set
    push_element(16'h0000, 16'h0000, 1'b1, 1'b0);
    // extremes, tie at the top score
    push_element(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    push_element(16'h0000, 16'hFFFF, 1'b0, 1'b0);
    push_element(16'h1234, 16'h0000, 1'b0, 1'b0);
    push_element(16'hABCD, 16'h8000, 1'b1, 1'b0);
    // all scores equal: newest first
    push_element(16'h0001, 16'h7FFF, 1'b0, 1'b0);
    push_element(16'h0002, 16'h7FFF, 1'b0, 1'b0);
    push_element(16'h0003, 16'h7FFF, 1'b1, 1'b0);
    // store full, last flag arrives on a dropped element
    queue_set(CAPACITY + 3, 0, 1'b0);

    // the set after the full one keeps offering while the receiver holds off
    total = 0;
    while (total < 90) begin
      if ($urandom_range(0, 9) == 0)
        n = $urandom_range(50, 70);
      else
        n = $urandom_range(1, 12);
      queue_set(n, $urandom_range(0, 2), total != 0 && $urandom_range(0, 5) == 0);
      total += n;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (element_q.size() == 0 && !offering);
    wait (ranked_q.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### descending_score_counting_sort_top.f
hdl/dscs_pkg.sv
hdl/dscs_if.sv
hdl/dscs_cell.sv
hdl/dscs_chain.sv
hdl/descending_score_counting_sort_top.sv
tb/descending_score_counting_sort_top_tb.sv
